>>> sv/apdu_chain_reassembler_core_macros.svh
// ----------------------------------------------------------------------------
// apdu chain reassembler assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef APDU_CHAIN_REASSEMBLER_CORE_MACROS_SVH
`define APDU_CHAIN_REASSEMBLER_CORE_MACROS_SVH

// same-cycle implication
`define ACR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// shared types and constants of the apdu chain reassembler
// ----------------------------------------------------------------------------
package acr_pkg;

    localparam int MAX_PACKET_DEF = 256;
    localparam int MAX_APDU_DEF   = 4096;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 9;
    localparam int LEN_W   = 13;

    // header byte layout
    localparam logic [BYTE_W-1:0] HDR_CHAIN_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] HDR_PRESENT    = 8'h08;

    localparam logic [2:0] CODE_NONE  = 3'h0;
    localparam logic [2:0] CODE_FIRST = 3'h1;
    localparam logic [2:0] CODE_INTER = 3'h2;
    localparam logic [2:0] CODE_LAST  = 3'h4;

    // configuration reset values
    localparam logic              PRESENCE_RST = 1'b0;
    localparam logic [SIZE_W-1:0] PKT_SIZE_RST = 9'd64;
    localparam logic [LEN_W-1:0]  CAPACITY_RST = 13'd4096;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_INTER  = 2'd2,
        KIND_LAST   = 2'd3
    } pkt_kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OVERFLOW = 3'd1,
        ST_CHAIN    = 3'd2,
        ST_PRESENCE = 3'd3,
        ST_SHORT    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_PRESENCE      = 2'd0,
        CFG_PACKET_SIZE   = 2'd1,
        CFG_APDU_CAPACITY = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              presence_enabled;
        logic [SIZE_W-1:0] packet_size;
        logic [LEN_W-1:0]  apdu_capacity;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              packet_start;
        logic              packet_end;
    } in_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              apdu_done;
        logic [LEN_W-1:0]  apdu_length;
        status_t           status;
    } result_t;

endpackage

>>> sv/acr_in_stage.sv
// ----------------------------------------------------------------------------
// acr_in_stage
// input register: captures one received beat for the checking logic
// ----------------------------------------------------------------------------
module acr_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  acr_pkg::in_beat_t in_beat,
    input  logic             take,
    output logic             stage_valid,
    output acr_pkg::in_beat_t stage_beat
);
    import acr_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    // empty, or the held beat moves on this cycle
    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

>>> sv/acr_engine.sv
// ----------------------------------------------------------------------------
// acr_engine
// header and length checks with the chain state registers
// ----------------------------------------------------------------------------
module acr_engine #(
    parameter int MAX_PACKET = acr_pkg::MAX_PACKET_DEF,
    parameter int MAX_APDU   = acr_pkg::MAX_APDU_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  acr_pkg::in_beat_t beat,
    input  acr_pkg::cfg_t     cfg,
    output acr_pkg::result_t  result
);
    import acr_pkg::*;

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int TW = $clog2(MAX_APDU + 1);
    localparam int CW = (PW > SIZE_W) ? PW : SIZE_W;
    localparam int AW = (TW > LEN_W) ? TW : LEN_W;

    logic          chain_open_reg, chain_open_next;
    pkt_kind_t     kind_reg, kind_next;
    logic [PW-1:0] pbytes_reg, pbytes_next;
    logic [TW-1:0] total_reg, total_next;
    logic          disc_reg, disc_next;

    logic [2:0]    code;
    logic          pres;
    logic [AW-1:0] cap_eff;
    logic [CW-1:0] psize_ext;
    logic          fail;
    status_t       st;
    logic          valid;
    logic [BYTE_W-1:0] ob;
    logic          done;

    assign code      = beat.rx_byte[2:0] & HDR_CHAIN_MASK[2:0];
    assign pres      = |(beat.rx_byte & HDR_PRESENT);
    assign psize_ext = CW'(cfg.packet_size);
    assign cap_eff   = (AW'(cfg.apdu_capacity) > AW'(MAX_APDU)) ?
                       AW'(MAX_APDU) : AW'(cfg.apdu_capacity);

    always_comb
    begin
        chain_open_next = chain_open_reg;
        kind_next       = kind_reg;
        pbytes_next     = pbytes_reg;
        total_next      = total_reg;
        disc_next       = disc_reg;
        st              = ST_OK;
        valid           = 1'b0;
        ob              = '0;
        done            = 1'b0;
        fail            = 1'b0;

        if (beat.packet_start)
        begin
            if (pbytes_reg != '0 && !disc_reg)
            begin
                // header inside an open packet
                st = ST_CHAIN;
            end
            else
            begin
                disc_next = 1'b0;
                if (pres != cfg.presence_enabled)
                begin
                    st = ST_PRESENCE;
                end
                else if (!chain_open_reg)
                begin
                    unique case (code)
                        CODE_NONE:
                        begin
                            kind_next  = KIND_SINGLE;
                            total_next = '0;
                        end
                        CODE_FIRST:
                        begin
                            kind_next  = KIND_FIRST;
                            total_next = '0;
                        end
                        default: st = ST_CHAIN;
                    endcase
                end
                else
                begin
                    unique case (code)
                        CODE_INTER: kind_next = KIND_INTER;
                        CODE_LAST:  kind_next = KIND_LAST;
                        default:    st = ST_CHAIN;
                    endcase
                end
            end
            if (st != ST_OK)
            begin
                fail = 1'b1;
            end
            else
            begin
                pbytes_next = PW'(1);
            end
        end
        else if (disc_reg)
        begin
            if (beat.packet_end)
            begin
                disc_next = 1'b0;
            end
        end
        else if (pbytes_reg != '0)
        begin
            if (kind_reg == KIND_INTER && CW'(pbytes_reg) >= psize_ext)
            begin
                st   = ST_SHORT;
                fail = 1'b1;
            end
            else if (AW'(total_reg) >= cap_eff)
            begin
                st   = ST_OVERFLOW;
                fail = 1'b1;
            end
            else
            begin
                valid      = 1'b1;
                ob         = beat.rx_byte;
                total_next = total_reg + TW'(1);
                if (pbytes_reg < PW'(MAX_PACKET))
                begin
                    pbytes_next = pbytes_reg + PW'(1);
                end
            end
        end

        // packet close on its last byte
        if (!fail && beat.packet_end && pbytes_next != '0 &&
            (beat.packet_start || valid))
        begin
            if (kind_next == KIND_INTER && CW'(pbytes_next) != psize_ext)
            begin
                st              = ST_SHORT;
                chain_open_next = 1'b0;
            end
            else if (kind_next == KIND_SINGLE || kind_next == KIND_LAST)
            begin
                done            = 1'b1;
                chain_open_next = 1'b0;
            end
            else
            begin
                chain_open_next = 1'b1;
            end
            pbytes_next = '0;
        end

        if (fail)
        begin
            chain_open_next = 1'b0;
            pbytes_next     = '0;
            disc_next       = !beat.packet_end;
        end
    end

    assign result.out_byte    = ob;
    assign result.byte_valid  = valid;
    assign result.apdu_done   = done;
    assign result.apdu_length = LEN_W'(total_next);
    assign result.status      = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_open_reg <= 1'b0;
            kind_reg       <= KIND_SINGLE;
            pbytes_reg     <= '0;
            total_reg      <= '0;
            disc_reg       <= 1'b0;
        end
        else if (step)
        begin
            chain_open_reg <= chain_open_next;
            kind_reg       <= kind_next;
            pbytes_reg     <= pbytes_next;
            total_reg      <= total_next;
            disc_reg       <= disc_next;
        end
    end

endmodule

>>> sv/acr_out_stage.sv
// ----------------------------------------------------------------------------
// acr_out_stage
// result register: holds one result beat until the receiver takes it
// ----------------------------------------------------------------------------
module acr_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load_valid,
    input  acr_pkg::result_t load_result,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output acr_pkg::result_t out_result
);
    import acr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load_valid)
        begin
            result_reg <= load_result;
        end
    end

endmodule

>>> sv/apdu_chain_reassembler_core.sv
// ----------------------------------------------------------------------------
// apdu_chain_reassembler_core
// receive-side reassembly of chained packets into apdu bytes
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid/in_ready) carries one received byte per beat,
//   with packet_start on the header byte and packet_end on the final byte
// - output channel (out_valid/out_ready) returns exactly one result beat per
//   input beat, in order: payload byte, completion flag, running length and
//   status
// - cfg channel (cfg_valid/cfg_ready) writes presence_enabled, packet_size or
//   apdu_capacity by index; cfg_ready is always high; write only while idle
// - the beat sits in the input register while the checking logic works on
//   it, and its result loads into the result register once that register
//   is free, which raises out_valid
// - throughput is one beat per cycle while out_ready holds high; the chain
//   state loop closes through the engine, so beats follow back to back
// - when the receiver stalls, the result register holds and the input
//   register still takes one more beat; beyond that in_ready drops
// - reset clears both pipeline registers, the chain state (idle, no packet
//   open, length zero, not discarding) and loads the default configuration
// ----------------------------------------------------------------------------
`include "apdu_chain_reassembler_core_macros.svh"

module apdu_chain_reassembler_core #(
    parameter int MAX_PACKET = acr_pkg::MAX_PACKET_DEF,
    parameter int MAX_APDU   = acr_pkg::MAX_APDU_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input beats
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [acr_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                         packet_start,
    input  logic                         packet_end,
    // result beats
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [acr_pkg::BYTE_W-1:0]   out_byte,
    output logic                         byte_valid,
    output logic                         apdu_done,
    output logic [acr_pkg::LEN_W-1:0]    apdu_length,
    output logic [2:0]                   status,
    // configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [acr_pkg::LEN_W-1:0]    cfg_data
);
    import acr_pkg::*;

    in_beat_t in_beat;
    in_beat_t stage_beat;
    logic     stage_valid;
    logic     out_free;
    logic     step;
    result_t  eng_result;
    result_t  out_result;
    cfg_t     cfg;
    logic     hard_err;

    logic              presence_reg;
    logic [SIZE_W-1:0] pkt_size_reg;
    logic [LEN_W-1:0]  capacity_reg;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg <= PRESENCE_RST;
            pkt_size_reg <= PKT_SIZE_RST;
            capacity_reg <= CAPACITY_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRESENCE:      presence_reg <= cfg_data[0];
                CFG_PACKET_SIZE:   pkt_size_reg <= cfg_data[SIZE_W-1:0];
                CFG_APDU_CAPACITY: capacity_reg <= cfg_data;
                default:           ; // unmapped index, write dropped
            endcase
        end
    end

    assign cfg.presence_enabled = presence_reg;
    assign cfg.packet_size      = pkt_size_reg;
    assign cfg.apdu_capacity    = capacity_reg;

    assign in_beat.rx_byte      = rx_byte;
    assign in_beat.packet_start = packet_start;
    assign in_beat.packet_end   = packet_end;

    // a held beat is processed whenever the result register can take it
    assign step = stage_valid && out_free;

    acr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_beat     (in_beat),
        .take        (out_free),
        .stage_valid (stage_valid),
        .stage_beat  (stage_beat)
    );

    acr_engine #(
        .MAX_PACKET (MAX_PACKET),
        .MAX_APDU   (MAX_APDU)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (stage_beat),
        .cfg    (cfg),
        .result (eng_result)
    );

    acr_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (stage_valid),
        .load_result (eng_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign out_byte    = out_result.out_byte;
    assign byte_valid  = out_result.byte_valid;
    assign apdu_done   = out_result.apdu_done;
    assign apdu_length = out_result.apdu_length;
    assign status      = out_result.status;

    // overflow, chain or presence error on the result beat
    assign hard_err = (status == ST_OVERFLOW) || (status == ST_CHAIN) ||
                      (status == ST_PRESENCE);

    // completion only on a clean close
    `ACR_ASSERT_IMPL(a_done_clean, out_valid && apdu_done, status == ST_OK, "done on error")

    // no payload passes with an overflow, chain or presence error
    `ACR_ASSERT_IMPL(a_err_no_byte, out_valid && hard_err, !byte_valid, "payload on error")

    // a processed beat always shows up as a result next cycle
    `ACR_ASSERT_NEXT(a_step_out, step, out_valid, "processed beat lost")

    // dropped payload slot carries a zero byte
    `ACR_ASSERT_IMPL(a_idle_byte, out_valid && !byte_valid, out_byte == '0, "stale byte")

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for apdu_chain_reassembler_core: a queue-fed driver
// sends received bytes in bursts, a scoreboard predicts one result beat per
// accepted byte and a monitor compares each returned beat field by field
// ----------------------------------------------------------------------------
module tb;
    import acr_pkg::*;

    // clock, reset and dut ports; every input starts at a known value
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   rx_byte = '0;
    logic                packet_start = 1'b0;
    logic                packet_end = 1'b0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                apdu_done;
    logic [LEN_W-1:0]    apdu_length;
    logic [2:0]          status;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [LEN_W-1:0]    cfg_data = '0;

    apdu_chain_reassembler_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .packet_start (packet_start),
        .packet_end   (packet_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .apdu_done    (apdu_done),
        .apdu_length  (apdu_length),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // bytes waiting to be sent and result beats still owed by the dut
    in_beat_t    pending_beats[$];
    result_t     expected_results[$];
    int unsigned beats_queued = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;

    // shadow copy of the configuration registers
    logic              cfg_presence = PRESENCE_RST;
    logic [SIZE_W-1:0] cfg_pkt_size = PKT_SIZE_RST;
    logic [LEN_W-1:0]  cfg_capacity = CAPACITY_RST;

    // shadow copy of the reassembly state
    logic        chain_open = 1'b0;   // a first or intermediate packet was closed, chain continues
    pkt_kind_t   cur_kind = KIND_SINGLE;
    int unsigned open_len = 0;        // bytes of the open packet, 0 = none open
    int unsigned apdu_total = 0;      // apdu bytes accepted so far
    logic        dropping = 1'b0;     // rest of a failed packet is being thrown away

    // sender burst/gap and receiver stall bookkeeping
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // reassembly predictor
    // ------------------------------------------------------------------------

    // end of an open packet: intermediates must be exactly packet_size long,
    // single and last packets finish the apdu, first and intermediate keep
    // the chain open
    function automatic status_t close_open_packet(output logic finished);
        status_t st;
        st = ST_OK;
        finished = 1'b0;
        if (cur_kind == KIND_INTER && open_len != cfg_pkt_size) begin
            st = ST_SHORT;
            chain_open = 1'b0;
        end else if (cur_kind == KIND_SINGLE || cur_kind == KIND_LAST) begin
            finished = 1'b1;
            chain_open = 1'b0;
        end else begin
            chain_open = 1'b1;
        end
        open_len = 0;
        return st;
    endfunction

    // advance the shadow state by one received byte, return the result beat
    function automatic result_t reassemble_beat(input logic [BYTE_W-1:0] b,
                                                input logic is_start,
                                                input logic is_end);
        result_t           r;
        status_t           st;
        logic              fail;
        logic              done;
        logic              valid;
        logic [BYTE_W-1:0] ob;
        logic [2:0]        code;
        logic              pres;
        int unsigned       cap;

        cap   = (cfg_capacity > MAX_APDU_DEF) ? MAX_APDU_DEF : cfg_capacity;
        st    = ST_OK;
        fail  = 1'b0;
        done  = 1'b0;
        valid = 1'b0;
        ob    = '0;

        if (is_start) begin
            if (open_len != 0 && !dropping) begin
                // header inside a packet that is still open
                st = ST_CHAIN;
            end else begin
                code     = 3'(b & HDR_CHAIN_MASK);
                pres     = |(b & HDR_PRESENT);
                dropping = 1'b0;
                if (pres != cfg_presence) begin
                    st = ST_PRESENCE;
                end else if (!chain_open) begin
                    if (code == CODE_NONE) begin
                        cur_kind   = KIND_SINGLE;
                        apdu_total = 0;
                    end else if (code == CODE_FIRST) begin
                        cur_kind   = KIND_FIRST;
                        apdu_total = 0;
                    end else begin
                        st = ST_CHAIN;
                    end
                end else begin
                    if (code == CODE_INTER)
                        cur_kind = KIND_INTER;
                    else if (code == CODE_LAST)
                        cur_kind = KIND_LAST;
                    else
                        st = ST_CHAIN;
                end
            end
            if (st != ST_OK) begin
                fail = 1'b1;
            end else begin
                open_len = 1;
                if (is_end)
                    st = close_open_packet(done);
            end
        end else if (dropping) begin
            if (is_end)
                dropping = 1'b0;
        end else if (open_len != 0) begin
            if (cur_kind == KIND_INTER && open_len >= cfg_pkt_size) begin
                st   = ST_SHORT;
                fail = 1'b1;
            end else if (apdu_total >= cap) begin
                st   = ST_OVERFLOW;
                fail = 1'b1;
            end else begin
                valid = 1'b1;
                ob    = b;
                apdu_total++;
                if (open_len < MAX_PACKET_DEF)
                    open_len++;
                if (is_end)
                    st = close_open_packet(done);
            end
        end
        // stray bytes with no packet open fall through with status ok

        if (fail) begin
            chain_open = 1'b0;
            open_len   = 0;
            dropping   = !is_end;
        end

        r.out_byte    = ob;
        r.byte_valid  = valid;
        r.apdu_done   = done;
        r.apdu_length = LEN_W'(apdu_total);
        r.status      = st;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic add_beat(input logic [BYTE_W-1:0] b, input logic is_start,
                            input logic is_end);
        in_beat_t beat;
        beat.rx_byte      = b;
        beat.packet_start = is_start;
        beat.packet_end   = is_end;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    // header plus len payload bytes, end flag on the last byte
    task automatic add_packet(input logic [BYTE_W-1:0] hdr, input int unsigned len);
        add_beat(hdr, 1'b1, len == 0);
        for (int unsigned i = 1; i <= len; i++)
            add_beat(BYTE_W'($urandom_range(255)), 1'b0, i == len);
    endtask

    // random upper nibble, presence bit mostly as configured
    function automatic logic [BYTE_W-1:0] header_byte(input logic [2:0] code);
        logic [3:0] upper;
        logic       pres;
        upper = 4'($urandom_range(15));
        pres  = ($urandom_range(19) == 0) ? ~cfg_presence : cfg_presence;
        return {upper, pres, code};
    endfunction

    // mostly short payloads, a few long enough to saturate the packet count
    function automatic int unsigned payload_len();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom_range(6);
        if (pick < 97)
            return $urandom_range(24, 7);
        return $urandom_range(300, 200);
    endfunction

    // intermediate payload fits packet_size exactly, now and then one off
    function automatic int unsigned inter_len();
        int unsigned body;
        if (cfg_pkt_size < 2 || cfg_pkt_size > MAX_PACKET_DEF)
            return payload_len();
        body = cfg_pkt_size - 1;
        case ($urandom_range(19))
            0:       return body - 1;
            1:       return body + 1;
            default: return body;
        endcase
    endfunction

    // one chunk of traffic: well-formed apdus, random headers or raw noise
    task automatic queue_traffic();
        int unsigned pick;
        int unsigned n_inter;
        pick = $urandom_range(99);
        if (pick < 35) begin
            add_packet(header_byte(CODE_NONE), payload_len());
        end else if (pick < 68) begin
            n_inter = $urandom_range(3);
            add_packet(header_byte(CODE_FIRST), payload_len());
            repeat (n_inter)
                add_packet(header_byte(CODE_INTER), inter_len());
            // sometimes the chain is left without its last packet
            if ($urandom_range(9) != 0)
                add_packet(header_byte(CODE_LAST), payload_len());
        end else if (pick < 88) begin
            add_packet(BYTE_W'($urandom_range(255)), payload_len());
        end else begin
            repeat ($urandom_range(6, 1))
                add_beat(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end
    endtask

    // register write on the cfg channel, shadow copy updated on acceptance
    task automatic write_reg(input cfg_index_t idx, input logic [LEN_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PRESENCE:      cfg_presence = val[0];
            CFG_PACKET_SIZE:   cfg_pkt_size = val[SIZE_W-1:0];
            CFG_APDU_CAPACITY: cfg_capacity = val;
            default:           ;
        endcase
    endtask

    // every beat sent and every result back; each byte gives one result,
    // so the dut is idle once the scoreboard is empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic run_phase(input logic pres, input logic [SIZE_W-1:0] size,
                             input logic [LEN_W-1:0] cap, input int unsigned beats);
        int unsigned target;
        write_reg(CFG_PRESENCE, LEN_W'(pres));
        write_reg(CFG_PACKET_SIZE, LEN_W'(size));
        write_reg(CFG_APDU_CAPACITY, cap);
        @(negedge clk);
        target = beats_queued + beats;
        while (beats_queued < target)
            queue_traffic();
        wait_drained();
    endtask

    task automatic report_mismatch(input string msg);
        $display("error: result beat %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // driver: present queued bytes in bursts, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : byte_driver
        in_beat_t beat;
        if (rst_n) begin
            if (in_valid && in_ready)
                expected_results.push_back(
                    reassemble_beat(rx_byte, packet_start, packet_end));
            if (!in_valid || in_ready) begin
                if (gap_left != 0 || pending_beats.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    beat = pending_beats.pop_front();
                    in_valid     <= 1'b1;
                    rx_byte      <= beat.rx_byte;
                    packet_start <= beat.packet_start;
                    packet_end   <= beat.packet_end;
                    if (burst_left != 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        // now and then a long run of back to back beats
                        if ($urandom_range(7) == 0) begin
                            burst_left = $urandom_range(300, 100);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(12, 1);
                            gap_left   = $urandom_range(5, 1);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each accepted result beat, drive receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %0h, expected %0h",
                                                  out_byte, want.out_byte));
                    if (byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                                  byte_valid, want.byte_valid));
                    if (apdu_done !== want.apdu_done)
                        report_mismatch($sformatf("apdu_done %0b, expected %0b",
                                                  apdu_done, want.apdu_done));
                    if (apdu_length !== want.apdu_length)
                        report_mismatch($sformatf("apdu_length %0d, expected %0d",
                                                  apdu_length, want.apdu_length));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                end
                results_seen++;
            end
            // stall pattern: windows of always-ready, half, quarter, mostly ready
            if (stall_left == 0) begin
                stall_mode = $urandom_range(3);
                stall_left = $urandom_range(200, 40);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(1) == 0);
                2:       out_ready <= ($urandom_range(3) == 0);
                default: out_ready <= ($urandom_range(9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: intermediates of 3 bytes, capacity above the maximum
        write_reg(CFG_PRESENCE, LEN_W'(1'b0));
        write_reg(CFG_PACKET_SIZE, LEN_W'(3));
        write_reg(CFG_APDU_CAPACITY, LEN_W'(8191));
        @(negedge clk);
        add_beat(8'hA5, 1'b0, 1'b0);   // stray byte, no packet open
        add_beat(8'h00, 1'b1, 1'b1);   // header-only single apdu
        add_beat(8'h08, 1'b1, 1'b0);   // presence mismatch
        add_beat(8'hFF, 1'b0, 1'b1);   // dropped byte ends the discard
        add_beat(8'h02, 1'b1, 1'b1);   // intermediate code while idle
        add_beat(8'h01, 1'b1, 1'b0);   // first packet
        add_beat(8'h00, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b1);   // chain stays open
        add_beat(8'h00, 1'b1, 1'b0);   // none code inside an open chain
        add_beat(8'h01, 1'b1, 1'b0);   // header while discarding is taken
        add_beat(8'h11, 1'b0, 1'b0);
        add_beat(8'h04, 1'b1, 1'b0);   // header inside an open packet
        add_beat(8'h01, 1'b1, 1'b0);   // header while discarding again
        add_beat(8'h22, 1'b0, 1'b1);
        add_beat(8'h02, 1'b1, 1'b0);   // intermediate
        add_beat(8'h33, 1'b0, 1'b0);
        add_beat(8'h44, 1'b0, 1'b0);
        add_beat(8'h55, 1'b0, 1'b1);   // one byte too many for packet_size
        add_beat(8'h01, 1'b1, 1'b0);
        add_beat(8'h77, 1'b0, 1'b1);
        add_beat(8'h02, 1'b1, 1'b1);   // intermediate that ends too short
        wait_drained();

        // zero capacity: the first payload byte overflows
        write_reg(CFG_APDU_CAPACITY, LEN_W'(0));
        @(negedge clk);
        add_beat(8'hF0, 1'b1, 1'b0);
        add_beat(8'h88, 1'b0, 1'b1);
        wait_drained();

        // random part, one configuration per phase; the drain at the end of
        // each phase holds the sender until every result is back; the last
        // chunk of a phase runs past its target, long payloads often by a lot
        run_phase(1'b1, 9'd4,   13'd4096, 80);
        run_phase(1'b0, 9'd2,   13'd8191, 80);
        run_phase(1'b1, 9'd8,   13'd40,   80);
        run_phase(1'b0, 9'd16,  13'd0,    70);
        run_phase(1'b1, 9'd256, 13'd4096, 40);
        run_phase(1'b0, 9'd0,   13'd12,   75);
        run_phase(1'b1, 9'd1,   13'd1,    75);
        run_phase(1'b0, 9'd511, 13'd300,  80);
        run_phase(1'b1, 9'd5,   13'd4095, 90);
        run_phase(1'b0, 9'd64,  13'd4096, 70);

        // wait on to catch any surplus result beat
        repeat (6) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("apdu_chain_reassembler_core: match");
        else
            $display("apdu_chain_reassembler_core: mismatch");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("apdu_chain_reassembler_core: mismatch");
        $finish;
    end

endmodule
